### src/ltok_pkg.sv
// shared types and constants of the line tokenizer
// beat payloads, token kinds, character codes and the front-to-back record
`default_nettype none

package ltok_pkg;

	// token kinds; 0 to 9 are the operator characters in OP_CHARS order
	localparam logic [4:0] K_NUMBER = 5'd10;
	localparam logic [4:0] K_IDENT  = 5'd11;
	localparam logic [4:0] K_VAR    = 5'd12;
	localparam logic [4:0] K_PRINT  = 5'd13;
	localparam logic [4:0] K_QUIT   = 5'd14;
	localparam logic [4:0] K_EOL    = 5'd15;
	localparam logic [4:0] K_ERROR  = 5'd16;

	localparam int OP_COUNT = 10;
	localparam logic [7:0] OP_CHARS [OP_COUNT] = '{
		"(", ")", "[", "]", ",", "-", "+", "*", "/", "="
	};

	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_POINT = ".";
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = " ";

	localparam int MANT_W = 54;
	// run length field, wide enough for the longest identifier of the parameter range
	localparam int LEN_W  = 6;

	typedef struct packed {
		logic [7:0] char_in;
		logic       line_last;
	} in_t;

	typedef struct packed {
		logic [4:0]        token_kind;
		logic [MANT_W-1:0] mantissa;
		logic [3:0]        fraction_digits;
		logic [7:0]        ident_char;
		logic              last_of_run;
	} out_t;

	// work for one input beat, in emission order a, b, c, d
	// a: flushed token (number, keyword, error, or identifier run)
	// b: operator or error from the current character
	// c: one-character token opened and closed by the line end
	// d: end of line
	typedef struct packed {
		logic              a_vld;
		logic              a_run;
		logic [4:0]        a_kind;
		logic [MANT_W-1:0] a_mant;
		logic [3:0]        a_frac;
		logic [LEN_W-1:0]  a_len;
		logic              b_vld;
		logic [4:0]        b_kind;
		logic              c_vld;
		logic              c_num;
		logic [7:0]        c_char;
		logic              d_vld;
	} rec_t;

endpackage

`default_nettype wire

### src/ltok_front.sv
// front part of the line tokenizer: classifies each character beat,
// keeps the scan state and writes a record for each beat that yields work; uses ltok_pkg
`default_nettype none

module ltok_front #(
	parameter int MAX_NUMBER_CHARS = 16,
	parameter int IDENT_LIMIT      = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  chr_valid,
	output logic                       chr_ready,
	input  wire ltok_pkg::in_t         chr_data,
	input  wire logic                  q_full,
	output logic                       push,
	output ltok_pkg::rec_t             push_rec,
	output logic [(IDENT_LIMIT-1)*8-1:0] push_run
);
	import ltok_pkg::*;

	localparam int BUF_DEPTH = IDENT_LIMIT - 1;
	localparam int CMAX = (MAX_NUMBER_CHARS > BUF_DEPTH) ? MAX_NUMBER_CHARS : BUF_DEPTH;
	localparam int CW = $clog2(CMAX + 1);
	localparam logic [23:0] KW_VAR   = "var";
	localparam logic [31:0] KW_QUIT  = "quit";
	localparam logic [39:0] KW_PRINT = "print";

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_NUM   = 4'b0010,
		PH_IDENT = 4'b0100,
		PH_DROP  = 4'b1000
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [MANT_W-1:0] acc_q, acc_n;
	logic [3:0]        frac_q, frac_n;
	logic              pt_q, pt_n;
	logic [CW-1:0]     chars_q, chars_n;
	logic              tok_q, tok_n;
	logic [7:0]        buf_q [BUF_DEPTH];
	logic [7:0]        buf_eff [BUF_DEPTH];
	logic [7:0]        buf_nxt [BUF_DEPTH];
	logic [7:0]        win [5];

	logic [7:0]        c;
	logic              accept;
	logic              is_dig, is_alpha, is_aln, is_pt, is_nl, is_sp, op_hit;
	logic [4:0]        op_idx;
	logic              wr_ident;
	logic [CW-1:0]     len_eff;
	logic              kw_var, kw_quit, kw_print;
	logic              id_run;
	logic [4:0]        id_kind;
	logic [MANT_W+3:0] prod;
	logic [MANT_W-1:0] acc_dig;
	logic              start_en, fl_id, fresh, fresh_alpha;
	rec_t              rec;

	assign c      = chr_data.char_in;
	assign accept = chr_valid && chr_ready;
	assign chr_ready = !q_full;

	assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign is_aln   = is_dig || is_alpha;
	assign is_pt    = (c == CH_POINT);
	assign is_nl    = (c == CH_NL);
	assign is_sp    = (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB);

	always_comb begin
		op_hit = 1'b0;
		op_idx = '0;
		for (int k = 0; k < OP_COUNT; k++) begin
			if (c == OP_CHARS[k]) begin
				op_hit = 1'b1;
				op_idx = 5'(k);
			end
		end
	end

	// digit append, saturating at all ones
	assign prod    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {{MANT_W{1'b0}}, c[3:0]};
	assign acc_dig = (prod[MANT_W+3:MANT_W] != 4'b0) ? {MANT_W{1'b1}} : prod[MANT_W-1:0];

	// identifier buffer as seen with this character appended
	assign wr_ident = (phase_q == PH_IDENT) && is_aln;
	assign len_eff  = wr_ident ? chars_q + CW'(1) : chars_q;

	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			buf_eff[i] = (wr_ident && (chars_q == CW'(i))) ? c : buf_q[i];
		end
	end

	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			push_run[i*8 +: 8] = buf_eff[i];
		end
	end

	for (genvar i = 0; i < 5; i++) begin : g_win
		if (i < BUF_DEPTH) begin : g_on
			assign win[i] = buf_eff[i];
		end else begin : g_off
			assign win[i] = '0;
		end
	end

	assign kw_var   = (len_eff == CW'(3)) && ({win[0], win[1], win[2]} == KW_VAR);
	assign kw_quit  = (len_eff == CW'(4)) && ({win[0], win[1], win[2], win[3]} == KW_QUIT);
	assign kw_print = (len_eff == CW'(5)) &&
		({win[0], win[1], win[2], win[3], win[4]} == KW_PRINT);

	assign id_run = !(kw_var || kw_quit || kw_print);

	always_comb begin
		priority if (kw_quit) begin
			id_kind = tok_q ? K_ERROR : K_QUIT;
		end else if (kw_var) begin
			id_kind = K_VAR;
		end else if (kw_print) begin
			id_kind = K_PRINT;
		end else begin
			id_kind = K_IDENT;
		end
	end

	always_comb begin
		rec         = '0;
		phase_n     = phase_q;
		acc_n       = acc_q;
		frac_n      = frac_q;
		pt_n        = pt_q;
		chars_n     = chars_q;
		tok_n       = tok_q;
		start_en    = 1'b0;
		fl_id       = 1'b0;
		fresh       = 1'b0;
		fresh_alpha = 1'b0;

		unique case (phase_q)
			PH_NUM: begin
				if (is_dig || is_pt) begin
					if (is_pt) begin
						pt_n = 1'b1;
					end else begin
						acc_n = acc_dig;
						if (pt_q && (frac_q != 4'hF)) begin
							frac_n = frac_q + 4'd1;
						end
					end
					chars_n = chars_q + CW'(1);
					if (chars_n >= CW'(MAX_NUMBER_CHARS)) begin
						rec.a_vld  = 1'b1;
						rec.a_kind = K_NUMBER;
						rec.a_mant = acc_n;
						rec.a_frac = frac_n;
						tok_n      = 1'b1;
						acc_n      = '0;
						frac_n     = '0;
						pt_n       = 1'b0;
						chars_n    = '0;
						phase_n    = PH_IDLE;
					end
				end else begin
					rec.a_vld  = 1'b1;
					rec.a_kind = K_NUMBER;
					rec.a_mant = acc_q;
					rec.a_frac = frac_q;
					tok_n      = 1'b1;
					acc_n      = '0;
					frac_n     = '0;
					pt_n       = 1'b0;
					chars_n    = '0;
					phase_n    = PH_IDLE;
					start_en   = 1'b1;
				end
			end
			PH_IDENT: begin
				if (is_aln) begin
					chars_n = chars_q + CW'(1);
					if (chars_n >= CW'(BUF_DEPTH)) begin
						fl_id = 1'b1;
					end
				end else begin
					fl_id    = 1'b1;
					start_en = !kw_quit;
				end
			end
			PH_IDLE: begin
				start_en = 1'b1;
			end
			PH_DROP: begin
			end
			default: begin
			end
		endcase

		if (fl_id) begin
			rec.a_vld  = 1'b1;
			rec.a_run  = id_run;
			rec.a_kind = id_kind;
			rec.a_len  = LEN_W'(len_eff);
			tok_n      = 1'b1;
			chars_n    = '0;
			phase_n    = kw_quit ? PH_DROP : PH_IDLE;
		end

		if (start_en) begin
			priority if (op_hit) begin
				rec.b_vld  = 1'b1;
				rec.b_kind = op_idx;
				tok_n      = 1'b1;
			end else if (is_sp) begin
			end else if (is_nl) begin
				phase_n = PH_DROP;
			end else if (is_dig) begin
				phase_n = PH_NUM;
				acc_n   = {{(MANT_W-4){1'b0}}, c[3:0]};
				frac_n  = '0;
				pt_n    = 1'b0;
				chars_n = CW'(1);
				fresh   = 1'b1;
			end else if (is_alpha) begin
				phase_n     = PH_IDENT;
				chars_n     = CW'(1);
				fresh       = 1'b1;
				fresh_alpha = 1'b1;
			end else begin
				rec.b_vld  = 1'b1;
				rec.b_kind = K_ERROR;
				phase_n    = PH_DROP;
			end
		end

		if (chr_data.line_last) begin
			if (phase_n == PH_NUM) begin
				if (fresh) begin
					rec.c_vld  = 1'b1;
					rec.c_num  = 1'b1;
					rec.c_char = c;
				end else begin
					rec.a_vld  = 1'b1;
					rec.a_kind = K_NUMBER;
					rec.a_mant = acc_n;
					rec.a_frac = frac_n;
				end
			end else if (phase_n == PH_IDENT) begin
				if (fresh) begin
					rec.c_vld  = 1'b1;
					rec.c_char = c;
				end else begin
					rec.a_vld  = 1'b1;
					rec.a_run  = id_run;
					rec.a_kind = id_kind;
					rec.a_len  = LEN_W'(len_eff);
				end
			end
			rec.d_vld = 1'b1;
			phase_n   = PH_IDLE;
			acc_n     = '0;
			frac_n    = '0;
			pt_n      = 1'b0;
			chars_n   = '0;
			tok_n     = 1'b0;
		end
	end

	always_comb begin
		buf_nxt = buf_eff;
		if (fresh_alpha) begin
			buf_nxt[0] = c;
		end
	end

	assign push_rec = rec;
	assign push     = accept && (rec.a_vld || rec.b_vld || rec.c_vld || rec.d_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			frac_q  <= '0;
			pt_q    <= 1'b0;
			chars_q <= '0;
			tok_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			frac_q  <= frac_n;
			pt_q    <= pt_n;
			chars_q <= chars_n;
			tok_q   <= tok_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= buf_nxt;
		end
	end

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && chr_data.line_last |=> (phase_q == PH_IDLE) && !tok_q && (chars_q == '0))
		else $error("scan state not cleared after line end");

	a_num_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NUM) |-> (chars_q < CW'(MAX_NUMBER_CHARS)))
		else $error("number longer than its limit");

endmodule

`default_nettype wire

### src/ltok_queue.sv
// two-entry record queue between the front and back parts of the tokenizer
// entries hold a record and the identifier bytes; uses ltok_pkg
`default_nettype none

module ltok_queue #(
	parameter int RUN_W = 120
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ltok_pkg::rec_t   push_rec,
	input  wire logic [RUN_W-1:0] push_run,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output ltok_pkg::rec_t        head_rec,
	output logic [RUN_W-1:0]      head_run
);
	import ltok_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);

	rec_t             rec_q [DEPTH];
	logic [RUN_W-1:0] run_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign full     = (cnt_q == (PW+1)'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_rec = rec_q[rd_ptr_q];
	assign head_run = run_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rec_q[wr_ptr_q] <= push_rec;
			run_q[wr_ptr_q] <= push_run;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("record queue overflow");

endmodule

`default_nettype wire

### src/ltok_back.sv
// back part of the line tokenizer: expands one record into token beats
// through a registered output stage; uses ltok_pkg
`default_nettype none

module ltok_back #(
	parameter int IDENT_LIMIT = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    empty,
	input  wire ltok_pkg::rec_t          head_rec,
	input  wire logic [(IDENT_LIMIT-1)*8-1:0] head_run,
	output logic                         pop,
	output logic                         tok_valid,
	input  wire logic                    tok_ready,
	output ltok_pkg::out_t               tok_data
);
	import ltok_pkg::*;

	localparam int BUF_DEPTH = IDENT_LIMIT - 1;
	localparam int RUN_W = BUF_DEPTH * 8;
	localparam int IW = $clog2(BUF_DEPTH);

	rec_t             cur_q;
	logic [RUN_W-1:0] run_q;
	logic [IW-1:0]    idx_q;
	out_t             out_q;
	logic             out_vld_q;

	logic pending, adv, last_in_a;
	out_t res;

	assign pending   = cur_q.a_vld || cur_q.b_vld || cur_q.c_vld || cur_q.d_vld;
	assign pop       = !empty && !pending;
	assign adv       = pending && (!out_vld_q || tok_ready);
	assign last_in_a = (LEN_W'(idx_q) == (cur_q.a_len - LEN_W'(1)));

	// next beat is taken from the first slot still open
	always_comb begin
		res = '0;
		priority if (cur_q.a_vld) begin
			if (cur_q.a_run) begin
				res.token_kind  = K_IDENT;
				res.ident_char  = run_q[{idx_q, 3'b000} +: 8];
				res.last_of_run = last_in_a && !cur_q.b_vld && !cur_q.c_vld && !cur_q.d_vld;
			end else begin
				res.token_kind      = cur_q.a_kind;
				res.mantissa        = cur_q.a_mant;
				res.fraction_digits = cur_q.a_frac;
				res.last_of_run     = !cur_q.b_vld && !cur_q.c_vld && !cur_q.d_vld;
			end
		end else if (cur_q.b_vld) begin
			res.token_kind  = cur_q.b_kind;
			res.last_of_run = !cur_q.c_vld && !cur_q.d_vld;
		end else if (cur_q.c_vld) begin
			if (cur_q.c_num) begin
				res.token_kind = K_NUMBER;
				res.mantissa   = {{(MANT_W-4){1'b0}}, cur_q.c_char[3:0]};
			end else begin
				res.token_kind = K_IDENT;
				res.ident_char = cur_q.c_char;
			end
			res.last_of_run = !cur_q.d_vld;
		end else if (cur_q.d_vld) begin
			res.token_kind  = K_EOL;
			res.last_of_run = 1'b1;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_q <= head_rec;
				idx_q <= '0;
			end else if (adv) begin
				priority if (cur_q.a_vld) begin
					if (cur_q.a_run && !last_in_a) begin
						idx_q <= idx_q + IW'(1);
					end else begin
						cur_q.a_vld <= 1'b0;
					end
				end else if (cur_q.b_vld) begin
					cur_q.b_vld <= 1'b0;
				end else if (cur_q.c_vld) begin
					cur_q.c_vld <= 1'b0;
				end else begin
					cur_q.d_vld <= 1'b0;
				end
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (tok_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			run_q <= head_run;
		end
		if (adv) begin
			out_q <= res;
		end
	end

	assign tok_valid = out_vld_q;
	assign tok_data  = out_q;

	a_record_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (cur_q.a_vld || cur_q.b_vld || cur_q.c_vld || cur_q.d_vld))
		else $error("empty record reached the back part");

	a_run_index: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.a_vld && cur_q.a_run |-> (LEN_W'(idx_q) < cur_q.a_len))
		else $error("identifier run index past its length");

endmodule

`default_nettype wire

### src/line_tokenizer.sv
// top level of the line tokenizer: front scanner, record queue, token emitter
// depends on ltok_pkg, ltok_front, ltok_queue and ltok_back
//
// usage:
//   chr channel (chr_valid/chr_ready/chr_data) carries one character beat with
//   a line_last mark; tok channel (tok_valid/tok_ready/tok_data) carries one
//   token beat, last_of_run set on the final token caused by a character.
//   the front takes a character every cycle while the two-entry record queue
//   has room; characters that cause no token (spaces, identifier and number
//   bodies, dropped line tails) are absorbed without writing a record.
//   the first token of a character leaves the output register after the queue
//   write, the record load and the output load. throughput at the output:
//   one token per cycle within a record while tok_ready is high; a record
//   is loaded only once the previous one is done, and it holds up to
//   IDENT_LIMIT tokens, so a long identifier run holds the queue, then chr_ready.
//   when tok_ready is low the output register holds its beat and the back part
//   waits; the queue keeps filling until full, then chr_ready drops.
//   reset clears the scan state, the queue and the output valid; the
//   identifier buffer is not cleared and needs no clearing.
`default_nettype none

module line_tokenizer #(
	parameter int MAX_NUMBER_CHARS = 16,
	parameter int IDENT_LIMIT      = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           chr_valid,
	output logic                chr_ready,
	input  wire ltok_pkg::in_t  chr_data,
	output logic                tok_valid,
	input  wire logic           tok_ready,
	output ltok_pkg::out_t      tok_data
);
	import ltok_pkg::*;

	// identifier bytes travel beside each record
	localparam int RUN_W = (IDENT_LIMIT - 1) * 8;

	logic             q_full, q_empty;
	logic             push, pop;
	rec_t             push_rec, head_rec;
	logic [RUN_W-1:0] push_run, head_run;

	// scanner: one character per cycle while the queue has room, at most one record per character
	ltok_front #(
		.MAX_NUMBER_CHARS(MAX_NUMBER_CHARS),
		.IDENT_LIMIT     (IDENT_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chr_valid(chr_valid),
		.chr_ready(chr_ready),
		.chr_data (chr_data),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec),
		.push_run (push_run)
	);

	// decouples the scanner from token emission
	ltok_queue #(
		.RUN_W(RUN_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.push_run(push_run),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head_rec(head_rec),
		.head_run(head_run)
	);

	// emitter: walks each record one token beat at a time
	ltok_back #(
		.IDENT_LIMIT(IDENT_LIMIT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head_rec (head_rec),
		.head_run (head_run),
		.pop      (pop),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_data (tok_data)
	);

endmodule

`default_nettype wire
